FILE: hdl/lfbd_pkg.sv
package lfbd_pkg;

  localparam int DATA_W    = 8;
  localparam int DIST_W    = 14;
  localparam int LEN_W     = 6;
  localparam int CNT_W     = 32;
  localparam int BITPOS_W  = 4;
  localparam int FLAG_BITS = 8;

  localparam logic [1:0] CFG_UNIT_SIZE     = 2'd0;
  localparam logic [1:0] CFG_LENGTH_BIAS   = 2'd1;
  localparam logic [1:0] CFG_OUTPUT_LENGTH = 2'd2;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_LIT,
    PH_TLOW,
    PH_THIGH
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COPY_RD,
    ST_COPY_WR
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
    logic              last;
    logic              finished;
    logic              bad;
  } emit_t;

  typedef struct packed {
    logic bad;
    logic at_limit;
    logic next_at_limit;
  } ref_status_t;

  function automatic phase_t select_phase(logic [BITPOS_W-1:0] bp,
                                          logic [FLAG_BITS-1:0] flags);
    phase_t ph;
    if (bp >= BITPOS_W'(FLAG_BITS)) begin
      ph = PH_FLAG;
    end else if (flags[bp[2:0]]) begin
      ph = PH_LIT;
    end else begin
      ph = PH_TLOW;
    end
    return ph;
  endfunction

endpackage

FILE: hdl/lfbd_ram.sv
module lfbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/lfbd_ref_unit.sv
module lfbd_ref_unit import lfbd_pkg::*; #(
  parameter int DEPTH  = 16384,
  parameter int ADDR_W = 14
) (
  input  logic [ADDR_W-1:0] wp,
  input  logic [DIST_W-1:0] back_dist,
  input  logic [CNT_W-1:0]  produced,
  input  logic [CNT_W-1:0]  output_length,
  output logic [ADDR_W-1:0] raddr,
  output ref_status_t       status
);

  logic [ADDR_W:0] dist_ext;
  logic [ADDR_W:0] diff;
  logic [ADDR_W:0] wrap;
  logic [CNT_W:0]  produced_inc;

  // Window address of the byte back_dist back, wrapped around the window.
  assign dist_ext = (ADDR_W+1)'(back_dist);
  assign diff     = {1'b0, wp} - dist_ext;
  assign wrap     = {1'b0, wp} + (ADDR_W+1)'(DEPTH) - dist_ext;
  assign raddr    = diff[ADDR_W] ? wrap[ADDR_W-1:0] : diff[ADDR_W-1:0];

  assign produced_inc = {1'b0, produced} + (CNT_W+1)'(1);

  always_comb begin
    status.bad           = (back_dist == '0) || (CNT_W'(back_dist) > produced);
    status.at_limit      = produced >= output_length;
    status.next_at_limit = produced_inc >= {1'b0, output_length};
  end

endmodule

FILE: hdl/lfbd_ctrl.sv
module lfbd_ctrl import lfbd_pkg::*; #(
  parameter int DEPTH  = 16384,
  parameter int ADDR_W = 14
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_byte,
  input  logic              in_last,
  input  logic [1:0]        unit,
  input  logic [1:0]        bias,
  input  logic              out_free,
  input  logic [DATA_W-1:0] rdata,
  input  ref_status_t       status,
  output emit_t             emit,
  output logic [ADDR_W-1:0] wp,
  output logic [DIST_W-1:0] back_dist,
  output logic [CNT_W-1:0]  produced
);

  state_t               state;
  state_t               state_next;
  phase_t               phase;
  phase_t               adv_phase;
  logic [BITPOS_W-1:0]  bitpos;
  logic [BITPOS_W-1:0]  bp_inc;
  logic [1:0]           lit_cnt;
  logic [FLAG_BITS-1:0] flag_bits;
  logic [DATA_W-1:0]    token_low;
  logic [DATA_W-1:0]    in_q;
  logic                 last_q;
  logic                 done_q;
  logic [LEN_W-1:0]     rem;
  logic [DIST_W-1:0]    dist_calc;
  logic [LEN_W-1:0]     len_calc;
  logic [15:0]          tok;
  logic                 lit_done;
  logic                 copy_end;
  logic                 active;
  logic [ADDR_W-1:0]    wp_inc;

  assign in_ready  = (state == ST_IDLE);
  assign tok       = {in_q, token_low};
  assign dist_calc = DIST_W'({2'b0, tok[15:4]} * {12'b0, unit});
  assign len_calc  = LEN_W'(({2'b0, tok[3:0]} + {4'b0, bias}) * {4'b0, unit});
  assign bp_inc    = bitpos + BITPOS_W'(1);
  assign adv_phase = select_phase(bp_inc, flag_bits);
  assign lit_done  = ({1'b0, lit_cnt} + 3'd1) >= {1'b0, unit};
  assign copy_end  = (rem == LEN_W'(1)) || status.next_at_limit;
  assign active    = !done_q && !status.at_limit;
  assign wp_inc    = (wp == ADDR_W'(DEPTH - 1)) ? '0 : wp + ADDR_W'(1);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (!active) begin
          state_next = ST_IDLE;
        end else begin
          case (phase)
            PH_LIT:   state_next = out_free ? ST_IDLE : ST_EXEC;
            PH_THIGH: state_next = (len_calc == '0) ? ST_IDLE : ST_COPY_RD;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_COPY_RD: state_next = ST_COPY_WR;
      ST_COPY_WR: begin
        if (out_free) state_next = copy_end ? ST_IDLE : ST_COPY_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    emit = '0;
    case (state)
      ST_EXEC: begin
        if (active && phase == PH_LIT && out_free) begin
          emit.valid    = 1'b1;
          emit.data     = in_q;
          emit.last     = 1'b1;
          emit.finished = status.next_at_limit || last_q;
        end
      end
      ST_COPY_WR: begin
        if (out_free) begin
          emit.valid    = 1'b1;
          emit.data     = status.bad ? '0 : rdata;
          emit.last     = copy_end;
          emit.finished = copy_end && (status.next_at_limit || last_q);
          emit.bad      = status.bad;
        end
      end
      default: emit = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_FLAG;
      bitpos    <= BITPOS_W'(FLAG_BITS);
      lit_cnt   <= '0;
      flag_bits <= '0;
      token_low <= '0;
      produced  <= '0;
      wp        <= '0;
      done_q    <= 1'b0;
    end else begin
      state <= state_next;
      if (emit.valid) begin
        wp       <= wp_inc;
        produced <= produced + CNT_W'(1);
      end
      case (state)
        ST_EXEC: begin
          if (!done_q) begin
            if (status.at_limit) begin
              done_q <= 1'b1;
            end else begin
              case (phase)
                PH_FLAG: begin
                  flag_bits <= in_q;
                  bitpos    <= '0;
                  phase     <= select_phase('0, in_q);
                  lit_cnt   <= '0;
                  done_q    <= last_q;
                end
                PH_TLOW: begin
                  token_low <= in_q;
                  phase     <= PH_THIGH;
                  done_q    <= last_q;
                end
                PH_LIT: begin
                  if (out_free) begin
                    if (lit_done) begin
                      bitpos  <= bp_inc;
                      phase   <= adv_phase;
                      lit_cnt <= '0;
                    end else begin
                      lit_cnt <= lit_cnt + 2'd1;
                    end
                    done_q <= emit.finished;
                  end
                end
                PH_THIGH: begin
                  back_dist <= dist_calc;
                  rem       <= len_calc;
                  if (len_calc == '0) begin
                    bitpos  <= bp_inc;
                    phase   <= adv_phase;
                    lit_cnt <= '0;
                    done_q  <= last_q;
                  end
                end
                default: phase <= PH_FLAG;
              endcase
            end
          end
        end
        ST_COPY_WR: begin
          if (out_free) begin
            rem <= rem - LEN_W'(1);
            if (copy_end) begin
              bitpos  <= bp_inc;
              phase   <= adv_phase;
              lit_cnt <= '0;
              done_q  <= emit.finished;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Payload latch for the transaction being worked on.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q   <= in_byte;
      last_q <= in_last;
    end
  end

  a_rd_then_wr: assert property (@(posedge clk) disable iff (rst)
    state == ST_COPY_RD |=> state == ST_COPY_WR)
    else $error("copy read not followed by copy write");

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    done_q |=> done_q)
    else $error("done flag dropped without reset");

  a_bad_is_zero: assert property (@(posedge clk) disable iff (rst)
    emit.valid && emit.bad |-> emit.data == '0)
    else $error("bad reference emitted nonzero data");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    emit.valid |-> !status.at_limit)
    else $error("byte emitted past output length");

  a_finish_on_last: assert property (@(posedge clk) disable iff (rst)
    emit.valid && emit.finished |-> emit.last)
    else $error("finished without end of transaction results");

endmodule

FILE: hdl/lzss_flag_byte_decompressor.sv
// A flag byte or token low byte is taken while idle and worked on in the exec state; a literal
// byte is emitted from the exec state and its result is registered in the output register.
// Copy: each byte of a copy token is a window read, then a write and emit; the write and emit
// wait while the output register is not free, and input is held until the whole token is done.
// Reset (synchronous, rst high) clears the sequencer, counters and config to defaults;
// the history window is not cleared, since a byte is only read back after it is written.
module lzss_flag_byte_decompressor import lfbd_pkg::*; #(
  parameter int WINDOW_DEPTH = 16384
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // compressed input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // in_last
  // decompressed output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,   // run_last
  output logic [1:0]  m_tuser    // [0] finished, [1] bad_reference
);

  localparam int ADDR_W = $clog2(WINDOW_DEPTH);

  logic [1:0]        unit_size;
  logic [1:0]        length_bias;
  logic [CNT_W-1:0]  output_length;
  logic [1:0]        unit;
  logic [1:0]        bias;
  logic              out_free;
  logic [DATA_W-1:0] rdata;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] wp;
  logic [DIST_W-1:0] back_dist;
  logic [CNT_W-1:0]  produced;
  ref_status_t       status;
  emit_t             emit;

  // Config registers; write them only while the block is idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_size     <= 2'd1;
      length_bias   <= 2'd2;
      output_length <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UNIT_SIZE:     unit_size     <= cfg_data[1:0];
        CFG_LENGTH_BIAS:   length_bias   <= cfg_data[1:0];
        CFG_OUTPUT_LENGTH: output_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // A unit size of zero acts as one; a bias of three saturates to two.
  assign unit = (unit_size == 2'd0) ? 2'd1 : unit_size;
  assign bias = (length_bias == 2'd3) ? 2'd2 : length_bias;

  // The output register frees up when empty or when its transaction completes.
  assign out_free = !m_tvalid || m_tready;

  lfbd_ctrl #(
    .DEPTH  (WINDOW_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .unit      (unit),
    .bias      (bias),
    .out_free  (out_free),
    .rdata     (rdata),
    .status    (status),
    .emit      (emit),
    .wp        (wp),
    .back_dist (back_dist),
    .produced  (produced)
  );

  // Shared address/compare unit: window read address, bad-reference check and
  // output length checks, all reused on every copied byte.
  lfbd_ref_unit #(
    .DEPTH  (WINDOW_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ref (
    .wp            (wp),
    .back_dist     (back_dist),
    .produced      (produced),
    .output_length (output_length),
    .raddr         (raddr),
    .status        (status)
  );

  // History window: every emitted byte, bad references included, is written back.
  lfbd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (emit.valid),
    .waddr (wp),
    .wdata (emit.data),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Output register: load on emit, drop valid once the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      m_tdata <= emit.data;
      m_tlast <= emit.last;
      m_tuser <= {emit.bad, emit.finished};
    end
  end

endmodule
